// File: design/rrsm_pkg.sv
// ----------------------------------------------------------------------------
// rrsm_pkg
// Shared widths, result record and controller states for the round-robin
// schedule metrics block.
// ----------------------------------------------------------------------------
package rrsm_pkg;

  localparam int unsigned MAX_PROCS = 64;
  localparam int unsigned IDX_W     = $clog2(MAX_PROCS);
  localparam int unsigned CNT_W     = IDX_W + 1;
  localparam int unsigned DATA_W    = 16;
  localparam int unsigned TIME_W    = 24;
  localparam int unsigned SUM_W     = 30;
  localparam int unsigned KEY_W     = DATA_W + IDX_W;

  typedef struct packed {
    logic [TIME_W-1:0] makespan;
    logic [SUM_W-1:0]  sum_response;
    logic [SUM_W-1:0]  sum_waiting;
    logic [SUM_W-1:0]  sum_turnaround;
    logic [TIME_W-1:0] response;
    logic [TIME_W-1:0] waiting;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] finish_time;
    logic [TIME_W-1:0] first_start;
    logic [IDX_W-1:0]  process_index;
    logic              last_result;
  } rrsm_result_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_RK_START,
    ST_RK_GETI,
    ST_RK_SCAN,
    ST_RK_DRAIN,
    ST_RK_WR,
    ST_MIG_RD,
    ST_MIG_CHK,
    ST_PICK,
    ST_PRD,
    ST_RUN,
    ST_OUT_RD,
    ST_OUT_WR
  } rrsm_state_t;

endpackage

// File: design/rrsm_ram.sv
// ----------------------------------------------------------------------------
// rrsm_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module rrsm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: design/rrsm_core.sv
// ----------------------------------------------------------------------------
// rrsm_core
// Process store and scheduling sequencer. Loads processes, ranks them by
// arrival, runs the round-robin simulation out of RAM and walks the results.
// ----------------------------------------------------------------------------
module rrsm_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rrsm_pkg::DATA_W-1:0]  in_arrival,
  input  logic [rrsm_pkg::DATA_W-1:0]  in_burst,
  input  logic                         in_last,
  input  logic [rrsm_pkg::DATA_W-1:0]  quantum,
  input  logic                         out_free,
  output logic                         res_load,
  output rrsm_pkg::rrsm_result_t       res
);
  import rrsm_pkg::*;

  rrsm_state_t state, state_next;

  logic [CNT_W-1:0]     cnt, n, i, j, ptr, qcnt;
  logic [IDX_W-1:0]     jd, rank, head, tail, p, pend;
  logic                 pv, pend_v;
  logic [DATA_W-1:0]    ai;
  logic [TIME_W-1:0]    cur_time;
  logic                 started;
  logic [SUM_W-1:0]     sum_ta, sum_wt, sum_rs;

  // memory ports
  logic              arr_we, bur_we, rem_we, fst_we, fin_we, ord_we, que_we;
  logic [IDX_W-1:0]  arr_waddr, rem_waddr, fst_waddr, fin_waddr, ord_waddr, que_waddr;
  logic [IDX_W-1:0]  arr_raddr, bur_raddr, rem_raddr, ord_raddr, que_raddr, out_raddr;
  logic [DATA_W-1:0] arr_rdata, bur_rdata, rem_rdata, rem_wdata;
  logic [TIME_W-1:0] fst_rdata, fin_rdata, fst_wdata, fin_wdata;
  logic [KEY_W-1:0]  ord_rdata, ord_wdata;
  logic [IDX_W-1:0]  que_rdata, que_wdata;

  // derived values
  logic [DATA_W-1:0] q_eff, run_left;
  logic              over, due, ptr_end, push, pop, rank_less, load_take, last_one;
  logic [TIME_W-1:0] ta, wt, rs;
  logic [SUM_W-1:0]  sum_ta_next, sum_wt_next, sum_rs_next;

  rrsm_ram #(.WIDTH(DATA_W), .DEPTH(MAX_PROCS)) u_arr (
    .clk, .we(arr_we), .waddr(arr_waddr), .wdata(in_arrival),
    .raddr(arr_raddr), .rdata(arr_rdata));
  rrsm_ram #(.WIDTH(DATA_W), .DEPTH(MAX_PROCS)) u_bur (
    .clk, .we(bur_we), .waddr(arr_waddr), .wdata(in_burst),
    .raddr(bur_raddr), .rdata(bur_rdata));
  rrsm_ram #(.WIDTH(DATA_W), .DEPTH(MAX_PROCS)) u_rem (
    .clk, .we(rem_we), .waddr(rem_waddr), .wdata(rem_wdata),
    .raddr(rem_raddr), .rdata(rem_rdata));
  rrsm_ram #(.WIDTH(TIME_W), .DEPTH(MAX_PROCS)) u_fst (
    .clk, .we(fst_we), .waddr(fst_waddr), .wdata(fst_wdata),
    .raddr(out_raddr), .rdata(fst_rdata));
  rrsm_ram #(.WIDTH(TIME_W), .DEPTH(MAX_PROCS)) u_fin (
    .clk, .we(fin_we), .waddr(fin_waddr), .wdata(fin_wdata),
    .raddr(out_raddr), .rdata(fin_rdata));
  rrsm_ram #(.WIDTH(KEY_W), .DEPTH(MAX_PROCS)) u_ord (
    .clk, .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
    .raddr(ord_raddr), .rdata(ord_rdata));
  rrsm_ram #(.WIDTH(IDX_W), .DEPTH(MAX_PROCS)) u_que (
    .clk, .we(que_we), .waddr(que_waddr), .wdata(que_wdata),
    .raddr(que_raddr), .rdata(que_rdata));

  // decode common conditions
  // remaining time is loaded with the burst, so it drops below the burst
  // once the process has had a turn that did not finish it
  assign q_eff     = (quantum == '0) ? DATA_W'(1) : quantum;
  assign run_left  = rem_rdata;
  assign started   = (rem_rdata != bur_rdata);
  assign over      = run_left > q_eff;
  assign due       = {{(TIME_W-DATA_W){1'b0}}, ord_rdata[KEY_W-1:IDX_W]} <= cur_time;
  assign ptr_end   = (ptr == n);
  assign rank_less = (arr_rdata < ai) || ((arr_rdata == ai) && (jd < i[IDX_W-1:0]));
  assign load_take = (state == ST_LOAD) && in_valid;
  assign last_one  = (i + CNT_W'(1)) == n;
  assign push      = ((state == ST_MIG_RD) && ptr_end && pend_v) ||
                     ((state == ST_MIG_CHK) && (due || pend_v));
  assign pop       = (state == ST_PRD);

  // result arithmetic
  assign ta          = fin_rdata - {{(TIME_W-DATA_W){1'b0}}, arr_rdata};
  assign wt          = ta - {{(TIME_W-DATA_W){1'b0}}, bur_rdata};
  assign rs          = fst_rdata - {{(TIME_W-DATA_W){1'b0}}, arr_rdata};
  assign sum_ta_next = sum_ta + {{(SUM_W-TIME_W){1'b0}}, ta};
  assign sum_wt_next = sum_wt + {{(SUM_W-TIME_W){1'b0}}, wt};
  assign sum_rs_next = sum_rs + {{(SUM_W-TIME_W){1'b0}}, rs};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:     if (in_valid && in_last) state_next = ST_RK_START;
      ST_RK_START: state_next = ST_RK_GETI;
      ST_RK_GETI:  state_next = ST_RK_SCAN;
      ST_RK_SCAN:  if (j == n) state_next = ST_RK_DRAIN;
      ST_RK_DRAIN: state_next = ST_RK_WR;
      ST_RK_WR:    state_next = last_one ? ST_MIG_RD : ST_RK_START;
      ST_MIG_RD: begin
        priority if (!ptr_end)       state_next = ST_MIG_CHK;
        else if (pend_v)             state_next = ST_PICK;
        else if (qcnt == '0)         state_next = ST_OUT_RD;
        else                         state_next = ST_PICK;
      end
      ST_MIG_CHK: begin
        priority if (due)            state_next = ST_MIG_RD;
        else if (pend_v)             state_next = ST_PICK;
        else if (qcnt == '0)         state_next = ST_MIG_RD;
        else                         state_next = ST_PICK;
      end
      ST_PICK:     state_next = ST_PRD;
      ST_PRD:      state_next = ST_RUN;
      ST_RUN:      state_next = ST_MIG_RD;
      ST_OUT_RD:   if (out_free) state_next = ST_OUT_WR;
      ST_OUT_WR:   state_next = last_one ? ST_LOAD : ST_OUT_RD;
      default:     state_next = ST_LOAD;
    endcase
  end

  // memory controls and result drive
  always_comb begin
    in_ready  = (state == ST_LOAD);
    arr_we    = load_take && !cnt[CNT_W-1];
    bur_we    = arr_we;
    arr_waddr = cnt[IDX_W-1:0];
    arr_raddr = (state == ST_RK_SCAN) ? j[IDX_W-1:0] : i[IDX_W-1:0];
    bur_raddr = (state == ST_PRD) ? que_rdata : i[IDX_W-1:0];
    rem_raddr = que_rdata;
    out_raddr = i[IDX_W-1:0];
    ord_raddr = ptr[IDX_W-1:0];
    que_raddr = head;

    // load the burst as remaining time, then count it down per turn
    rem_we    = arr_we || ((state == ST_RUN) && over);
    rem_waddr = (state == ST_RUN) ? p : cnt[IDX_W-1:0];
    rem_wdata = (state == ST_RUN) ? run_left - q_eff : in_burst;
    fst_we    = (state == ST_RUN) && !started;
    fst_waddr = p;
    fst_wdata = cur_time;
    fin_we    = (state == ST_RUN) && !over;
    fin_waddr = p;
    fin_wdata = cur_time + {{(TIME_W-DATA_W){1'b0}}, run_left};

    ord_we    = (state == ST_RK_WR);
    ord_waddr = rank;
    ord_wdata = {ai, i[IDX_W-1:0]};

    que_we    = push;
    que_waddr = tail;
    que_wdata = ((state == ST_MIG_CHK) && due) ? ord_rdata[IDX_W-1:0] : pend;

    res_load           = (state == ST_OUT_WR);
    res.process_index  = i[IDX_W-1:0];
    res.first_start    = fst_rdata;
    res.finish_time    = fin_rdata;
    res.turnaround     = ta;
    res.waiting        = wt;
    res.response       = rs;
    res.last_result    = last_one;
    res.sum_turnaround = last_one ? sum_ta_next : '0;
    res.sum_waiting    = last_one ? sum_wt_next : '0;
    res.sum_response   = last_one ? sum_rs_next : '0;
    res.makespan       = last_one ? cur_time : '0;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // load count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load_take) begin
      if (in_last) begin
        cnt <= '0;
      end else if (!cnt[CNT_W-1]) begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  // rank pipeline: compare the entry read last cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else begin
      pv <= (state == ST_RK_SCAN) && (j != n);
    end
    jd <= j[IDX_W-1:0];
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      n        <= '0;
      i        <= '0;
      j        <= '0;
      rank     <= '0;
      ptr      <= '0;
      head     <= '0;
      tail     <= '0;
      qcnt     <= '0;
      pend_v   <= 1'b0;
      cur_time <= '0;
      sum_ta   <= '0;
      sum_wt   <= '0;
      sum_rs   <= '0;
    end else begin
      // queue tail and occupancy
      if (push) begin
        tail <= tail + IDX_W'(1);
      end
      if (push && !pop) begin
        qcnt <= qcnt + CNT_W'(1);
      end else if (pop && !push) begin
        qcnt <= qcnt - CNT_W'(1);
      end

      unique case (state)
        ST_LOAD: begin
          if (in_valid && in_last) begin
            n        <= cnt[CNT_W-1] ? cnt : cnt + CNT_W'(1);
            i        <= '0;
            ptr      <= '0;
            head     <= '0;
            tail     <= '0;
            qcnt     <= '0;
            pend_v   <= 1'b0;
            cur_time <= '0;
            sum_ta   <= '0;
            sum_wt   <= '0;
            sum_rs   <= '0;
          end
        end
        ST_RK_START: begin
          rank <= '0;
        end
        ST_RK_GETI: begin
          ai <= arr_rdata;
          j  <= '0;
        end
        ST_RK_SCAN: begin
          if (j != n) begin
            j <= j + CNT_W'(1);
          end
          if (pv && rank_less) begin
            rank <= rank + IDX_W'(1);
          end
        end
        ST_RK_DRAIN: begin
          if (pv && rank_less) begin
            rank <= rank + IDX_W'(1);
          end
        end
        ST_RK_WR: begin
          i <= last_one ? '0 : i + CNT_W'(1);
        end
        ST_MIG_RD: begin
          if (ptr_end && pend_v) begin
            pend_v <= 1'b0;
          end
        end
        ST_MIG_CHK: begin
          priority if (due) begin
            ptr <= ptr + CNT_W'(1);
          end else if (pend_v) begin
            pend_v <= 1'b0;
          end else if (qcnt == '0) begin
            cur_time <= {{(TIME_W-DATA_W){1'b0}}, ord_rdata[KEY_W-1:IDX_W]};
          end else begin
            pend_v <= pend_v;
          end
        end
        ST_PICK: begin
          pend_v <= pend_v;
        end
        ST_PRD: begin
          p    <= que_rdata;
          head <= head + IDX_W'(1);
        end
        ST_RUN: begin
          if (over) begin
            cur_time <= cur_time + {{(TIME_W-DATA_W){1'b0}}, q_eff};
            pend     <= p;
            pend_v   <= 1'b1;
          end else begin
            cur_time <= fin_wdata;
          end
        end
        ST_OUT_RD: begin
          pend_v <= pend_v;
        end
        ST_OUT_WR: begin
          sum_ta <= sum_ta_next;
          sum_wt <= sum_wt_next;
          sum_rs <= sum_rs_next;
          i      <= last_one ? '0 : i + CNT_W'(1);
        end
        default: begin
          pend_v <= 1'b0;
        end
      endcase
    end
  end

endmodule

// File: design/round_robin_schedule_metrics.sv
// ----------------------------------------------------------------------------
// round_robin_schedule_metrics
// Round-robin scheduling simulator: loads a process set, simulates it with
// the configured quantum and streams per-process timing metrics.
// ----------------------------------------------------------------------------
//  channel  | direction | moves
//  cfg      | in        | quantum write (16 bits)
//  s_axis   | in        | one process request: arrival, burst, tlast = last
//  m_axis   | out       | one metrics result per process, tlast = last
//
//  Loading takes one request per cycle. After the request with tlast the
//  block ranks the set by arrival, then simulates; each turn is paced by
//  the single read port of the queue and order RAMs and grows with each
//  newly arrived process. Results leave through the output register, the
//  next loaded only once m_axis_tready frees it. Reset (rst, synchronous)
//  sets quantum to 2 and empties the set; no clearing pass is needed.
// ----------------------------------------------------------------------------
module round_robin_schedule_metrics (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [15:0]   cfg_data,        // quantum
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [31:0]   s_axis_tdata,    // arrival_time[15:0], burst_time[31:16]
  input  logic          s_axis_tlast,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [239:0]  m_axis_tdata,    // process_index, first_start, finish_time,
                                         // turnaround, waiting, response,
                                         // sum_turnaround, sum_waiting,
                                         // sum_response, makespan
  output logic          m_axis_tlast
);
  import rrsm_pkg::*;

  logic [DATA_W-1:0] quantum;
  logic              out_free, res_load;
  rrsm_result_t      res, out_reg;

  // quantum register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      quantum <= DATA_W'(2);
    end else if (cfg_valid) begin
      quantum <= cfg_data;
    end
  end

  rrsm_core u_core (
    .clk,
    .rst,
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_arrival (s_axis_tdata[15:0]),
    .in_burst   (s_axis_tdata[31:16]),
    .in_last    (s_axis_tlast),
    .quantum,
    .out_free,
    .res_load,
    .res
  );

  // output register
  assign out_free = !m_axis_tvalid || m_axis_tready;
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_reg <= res;
    end
  end

  assign m_axis_tdata = {out_reg.makespan, out_reg.sum_response, out_reg.sum_waiting,
                         out_reg.sum_turnaround, out_reg.response, out_reg.waiting,
                         out_reg.turnaround, out_reg.finish_time, out_reg.first_start,
                         out_reg.process_index};
  assign m_axis_tlast = out_reg.last_result;

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the round-robin schedule metrics block. Process
// requests are streamed in sets, a local scheduler predicts the per-process
// metrics of each set, and every result is compared field by field.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rrsm_pkg::*;

  localparam int unsigned STALL_LIMIT = 400000;
  localparam int unsigned SETTLE      = 40;

  logic         clk;
  logic         rst;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [15:0]  cfg_data;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata;    // arrival_time[15:0], burst_time[31:16]
  logic         s_axis_tlast;    // last_process
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [239:0] m_axis_tdata;    // process_index, first_start, finish_time, turnaround,
                                 // waiting, response, sum_turnaround, sum_waiting,
                                 // sum_response, makespan
  logic         m_axis_tlast;    // last_result

  round_robin_schedule_metrics i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // scheduler shadow state
  int unsigned   quantum_q;
  int unsigned   arr_mem [MAX_PROCS];
  int unsigned   burst_mem [MAX_PROCS];
  int unsigned   loaded;
  rrsm_result_t  metrics_q[$];

  int unsigned errors;
  int unsigned n_requests;
  int unsigned n_results;
  int unsigned n_sets;
  bit          tx_calm;
  bit          rx_calm;

  // Simulate one set round robin and queue its metrics in load order.
  function automatic void schedule_set();
    int unsigned  q;
    int unsigned  now;
    int unsigned  key [MAX_PROCS];
    int unsigned  rem [MAX_PROCS];
    int unsigned  fs [MAX_PROCS];
    int unsigned  fin [MAX_PROCS];
    bit           began [MAX_PROCS];
    int           order[$];
    int           j;
    int           p;
    int unsigned  ta, wt, rs, st, sw, sr;
    rrsm_result_t r;
    q   = (quantum_q == 0) ? 1 : quantum_q;
    now = 0;
    st = 0; sw = 0; sr = 0;
    for (int i = 0; i < loaded; i++) begin
      rem[i]   = burst_mem[i];
      began[i] = 1'b0;
      key[i]   = arr_mem[i];
      j = order.size();
      while (j > 0 && key[order[j-1]] > key[i]) j--;
      order.insert(j, i);
    end
    while (order.size() > 0) begin
      p = order[0];
      if (key[p] > now) begin
        now = key[p];
      end else begin
        if (!began[p]) begin
          began[p] = 1'b1;
          fs[p] = now;
        end
        void'(order.pop_front());
        if (rem[p] > q) begin
          now += q;
          rem[p] -= q;
          key[p] = now;
          j = 0;
          while (j < order.size() && key[order[j]] <= now) j++;
          order.insert(j, p);
        end else begin
          now += rem[p];
          rem[p] = 0;
          fin[p] = now;
        end
      end
    end
    for (int i = 0; i < loaded; i++) begin
      ta = fin[i] - arr_mem[i];
      wt = ta - burst_mem[i];
      rs = fs[i] - arr_mem[i];
      st += ta; sw += wt; sr += rs;
      r = '0;
      r.process_index = i[IDX_W-1:0];
      r.first_start   = fs[i][TIME_W-1:0];
      r.finish_time   = fin[i][TIME_W-1:0];
      r.turnaround    = ta[TIME_W-1:0];
      r.waiting       = wt[TIME_W-1:0];
      r.response      = rs[TIME_W-1:0];
      if (i + 1 == loaded) begin
        r.sum_turnaround = st[SUM_W-1:0];
        r.sum_waiting    = sw[SUM_W-1:0];
        r.sum_response   = sr[SUM_W-1:0];
        r.makespan       = now[TIME_W-1:0];
        r.last_result    = 1'b1;
      end
      metrics_q.push_back(r);
    end
    loaded = 0;
  endfunction

  // Send one process request, then record it in the shadow state.
  task automatic send_request(input int unsigned arr, input int unsigned burst,
                              input bit last);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {burst[15:0], arr[15:0]};
    s_axis_tlast  = last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    n_requests++;
    if (loaded < MAX_PROCS) begin
      arr_mem[loaded]   = arr[15:0];
      burst_mem[loaded] = burst[15:0];
      loaded++;
    end
    if (last) begin
      schedule_set();
      n_sets++;
    end
    @(negedge clk);
    if (last) s_axis_tvalid = 1'b0;
  endtask

  // Let the block drain, then write the quantum.
  task automatic write_quantum(input int unsigned q);
    while (metrics_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = q[15:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    quantum_q = q[15:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Random set: small bursts under small quanta keep turn counts bounded.
  task automatic random_set(input int unsigned size, input bit wide_arrival);
    int unsigned q, arr, burst, top;
    q   = (quantum_q == 0) ? 1 : quantum_q;
    top = (q * 20 > 65535) ? 65535 : q * 20;
    tx_calm = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < size; i++) begin
      arr   = wide_arrival ? $urandom_range(0, 65535) : $urandom_range(0, 60);
      burst = $urandom_range(0, top);
      send_request(arr, burst, i + 1 == size);
    end
  endtask

  task automatic test_directed_edges();
    tx_calm = 1'b0;
    // default quantum, single process and a zero burst
    send_request(0, 0, 1'b1);
    send_request(3, 5, 1'b0);
    send_request(3, 0, 1'b0);
    send_request(0, 7, 1'b0);
    send_request(3, 1, 1'b1);
    // full-scale fields under the widest quantum, with tied arrivals
    write_quantum(65535);
    send_request(65535, 65535, 1'b0);
    send_request(0, 65535, 1'b0);
    send_request(0, 0, 1'b0);
    send_request(65535, 1, 1'b0);
    send_request(43690, 21845, 1'b0);
    send_request(21845, 43690, 1'b1);
  endtask

  task automatic test_zero_quantum();
    write_quantum(0);
    send_request(0, 3, 1'b0);
    send_request(1, 2, 1'b0);
    send_request(1, 0, 1'b0);
    send_request(10, 4, 1'b1);
    write_quantum(1);
    random_set(8, 1'b0);
  endtask

  task automatic test_overflow();
    // past the capacity: extra requests are dropped, tlast still starts the run
    write_quantum(3);
    tx_calm = 1'b1;
    for (int i = 0; i < MAX_PROCS + 3; i++)
      send_request($urandom_range(0, 40), $urandom_range(0, 12), i == MAX_PROCS + 2);
  endtask

  task automatic test_random_sets();
    int unsigned start;
    start = n_requests;
    while (n_requests - start < 190) begin
      case ($urandom_range(0, 5))
        0:       write_quantum($urandom_range(4096, 65535));
        1:       write_quantum($urandom_range(1, 8));
        2:       write_quantum($urandom_range(0, 65535));
        default: ;
      endcase
      if ($urandom_range(0, 9) == 0) random_set($urandom_range(17, MAX_PROCS), 1'b0);
      else random_set($urandom_range(1, 12), 1'($urandom_range(0, 1)));
    end
  endtask

  function automatic void check_field(string name, longint unsigned exp_v,
                                      longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Accept results with random stalls and compare against the oldest metrics.
  initial begin
    rrsm_result_t e;
    int unsigned  stall;
    m_axis_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (n_results % 16 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      stall = rx_calm ? 0 : $urandom_range(0, 11);
      if (stall != 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready = 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      n_results++;
      if (metrics_q.size() == 0) begin
        $error("result with no request pending: index %0d", m_axis_tdata[5:0]);
        errors++;
      end else begin
        e = metrics_q.pop_front();
        check_field("process_index",  e.process_index,  m_axis_tdata[5:0]);
        check_field("first_start",    e.first_start,    m_axis_tdata[29:6]);
        check_field("finish_time",    e.finish_time,    m_axis_tdata[53:30]);
        check_field("turnaround",     e.turnaround,     m_axis_tdata[77:54]);
        check_field("waiting",        e.waiting,        m_axis_tdata[101:78]);
        check_field("response",       e.response,       m_axis_tdata[125:102]);
        check_field("sum_turnaround", e.sum_turnaround, m_axis_tdata[155:126]);
        check_field("sum_waiting",    e.sum_waiting,    m_axis_tdata[185:156]);
        check_field("sum_response",   e.sum_response,   m_axis_tdata[215:186]);
        check_field("makespan",       e.makespan,       m_axis_tdata[239:216]);
        check_field("last_result",    e.last_result,    m_axis_tlast);
      end
      @(negedge clk);
    end
  end

  // Abort when no channel moves for too long.
  int unsigned idle_cycles;
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", idle_cycles);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    errors = 0; n_requests = 0; n_results = 0; n_sets = 0;
    quantum_q = 2;
    loaded    = 0;
    tx_calm   = 1'b0;
    rx_calm   = 1'b0;
    repeat (10) @(negedge clk);
    rst = 1'b0;
    test_directed_edges();
    test_zero_quantum();
    test_overflow();
    test_random_sets();
    while (metrics_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    $display("Covered %0d process requests in %0d sets, %0d metric results checked.",
             n_requests, n_sets, n_results);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/rrsm_pkg.sv
design/rrsm_ram.sv
design/rrsm_core.sv
design/round_robin_schedule_metrics.sv
tb/sv/tb_top.sv
